// ===== design/bbn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_pkg: shared types and constants of the bounding-box normaliser
// Command codes, coordinate limits and the word carried from front to back.
// ----------------------------------------------------------------------------
package bbn_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_MEASURE   = 2'd1,
    CMD_TRANSFORM = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;
  localparam logic [16:0] OUT_ONE = 17'h1_0000;

  typedef struct packed {
    cmd_t              cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } job_t;

endpackage
`default_nettype wire

// ===== design/bbn_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_in_if / bbn_out_if: valid-ready channels of the normaliser
// Input carries a command and a vertex, output carries one normalised vertex.
// ----------------------------------------------------------------------------
interface bbn_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  modport source (output valid, command, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, command, coord_x, coord_y, coord_z, output ready);
endinterface

interface bbn_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] norm_x;
  logic signed [17:0] norm_y;
  logic signed [17:0] norm_z;
  logic               degenerate;
  modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
  modport sink   (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== design/bounding_box_normalizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounding_box_normalizer_top: mesh normalisation into the unit cube
// Input channel in_ch takes a command word (clear, measure, transform) with
// a Q16.16 vertex; output channel out_ch gives one Q1.16 vertex and a
// degenerate flag for every transform, nothing for the other commands.
// A front stage takes words into a two-entry queue; the back stage drains it.
// Clear and measure complete when the back stage pops them. A transform
// runs its three axes through one shared multiplier (difference, multiply,
// saturate for each) and holds the result until out_ch takes it. The first
// transform after a clear or measure first finds the largest extent, then
// divides 2^32 by it bit-serially, one quotient bit per cycle. With an empty
// or flat box the division is skipped.
// Synchronous reset rst empties the queue, clears the box and the scale.
// While out_ch is stalled the result holds; the queue still takes up to two
// words before in_ch.ready drops.
// ----------------------------------------------------------------------------
module bounding_box_normalizer_top (
  input wire logic  clk,
  input wire logic  rst,
  bbn_in_if.sink    in_ch,
  bbn_out_if.source out_ch
);
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  bbn_pkg::job_t q_in;
  bbn_pkg::job_t q_out;

  bbn_front u_front (.in_ch(in_ch), .q_full(q_full), .q_push(q_push), .q_data(q_in));

  bbn_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
  );

  bbn_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// ===== design/bbn_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_queue: short first-in first-out queue between front and back
// Two-entry register queue of accepted command words.
// ----------------------------------------------------------------------------
module bbn_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire bbn_pkg::job_t push_data,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output bbn_pkg::job_t    pop_data
);
  bbn_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && not_empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push && !full) - 2'(pop && not_empty);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
      (push && !full && !(pop && not_empty)) |=> count == $past(count) + 2'd1)
    else $error("queue push lost");
endmodule
`default_nettype wire

// ===== design/bbn_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_front: input stage of the normaliser
// Accept words, drop unused commands and pass the rest to the queue.
// ----------------------------------------------------------------------------
module bbn_front (
  bbn_in_if.sink           in_ch,
  input  wire logic        q_full,
  output logic             q_push,
  output bbn_pkg::job_t    q_data
);
  assign in_ch.ready = !q_full;
  assign q_data.cmd  = bbn_pkg::cmd_t'(in_ch.command);
  assign q_data.x    = in_ch.coord_x;
  assign q_data.y    = in_ch.coord_y;
  assign q_data.z    = in_ch.coord_z;
  assign q_push      = in_ch.valid && !q_full &&
                       (bbn_pkg::cmd_t'(in_ch.command) != bbn_pkg::CMD_UNUSED);
endmodule
`default_nettype wire

// ===== design/bbn_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_back: execution stage of the normaliser
// Hold the box, divide 2^32 by the extent bit-serially, then scale each axis
// through one shared multiplier and saturate.
// ----------------------------------------------------------------------------
module bbn_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire bbn_pkg::job_t q_data,
  output logic             q_pop,
  bbn_out_if.source        out_ch
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXT   = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_DIFF  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_SAT   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic signed [31:0] box_min [3];
  logic signed [31:0] box_max [3];
  logic [31:0] scale_factor;
  logic        scale_ready;
  logic        empty;
  logic [32:0] largest;
  logic [33:0] rem;
  logic [32:0] quo;
  logic [5:0]  div_cnt;
  logic [1:0]  axis;
  logic signed [31:0] pt [3];
  logic [33:0] mag;
  logic        neg;
  logic [65:0] prod;
  logic [17:0] res [3];
  logic signed [33:0] d2;
  logic signed [32:0] ext_a;
  logic [33:0] rem_sh;
  logic [49:0] shifted;
  logic [16:0] r;

  always_comb begin
    d2 = ({{2{pt[axis][31]}}, pt[axis]} <<< 1)
       - ({{2{box_min[axis][31]}}, box_min[axis]}
        + {{2{box_max[axis][31]}}, box_max[axis]});
    ext_a = {box_max[axis][31], box_max[axis]} - {box_min[axis][31], box_min[axis]};
    rem_sh = {rem[32:0], (div_cnt == 6'd32)};
    shifted = prod[65:16];
    r = (shifted > 50'(bbn_pkg::OUT_ONE)) ? bbn_pkg::OUT_ONE : shifted[16:0];
  end

  assign q_pop             = (state == S_IDLE) && q_valid;
  assign out_ch.valid      = (state == S_OUT);
  assign out_ch.norm_x     = res[0];
  assign out_ch.norm_y     = res[1];
  assign out_ch.norm_z     = res[2];
  assign out_ch.degenerate = (scale_factor == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scale_factor <= 32'd0;
      scale_ready  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= bbn_pkg::POS_MAX;
        box_max[a] <= bbn_pkg::NEG_MAX;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            pt[0] <= q_data.x;
            pt[1] <= q_data.y;
            pt[2] <= q_data.z;
            axis  <= 2'd0;
            unique case (q_data.cmd)
              bbn_pkg::CMD_CLEAR: begin
                scale_ready <= 1'b0;
                for (int a = 0; a < 3; a++) begin
                  box_min[a] <= bbn_pkg::POS_MAX;
                  box_max[a] <= bbn_pkg::NEG_MAX;
                end
              end
              bbn_pkg::CMD_MEASURE: begin
                scale_ready <= 1'b0;
                if (q_data.x < box_min[0]) box_min[0] <= q_data.x;
                if (q_data.x > box_max[0]) box_max[0] <= q_data.x;
                if (q_data.y < box_min[1]) box_min[1] <= q_data.y;
                if (q_data.y > box_max[1]) box_max[1] <= q_data.y;
                if (q_data.z < box_min[2]) box_min[2] <= q_data.z;
                if (q_data.z > box_max[2]) box_max[2] <= q_data.z;
              end
              bbn_pkg::CMD_TRANSFORM: begin
                largest <= 33'd0;
                empty   <= 1'b0;
                state   <= scale_ready ? S_DIFF : S_EXT;
              end
              default: ;
            endcase
          end
        end
        S_EXT: begin
          if (ext_a < 0) empty <= 1'b1;
          else if (33'(ext_a) > largest) largest <= 33'(ext_a);
          if (axis == 2'd2) begin
            axis    <= 2'd0;
            rem     <= 34'd0;
            quo     <= 33'd0;
            div_cnt <= 6'd32;
            state   <= S_DIV;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_DIV: begin
          if (empty || largest == 33'd0) begin
            scale_factor <= 32'd0;
            scale_ready  <= 1'b1;
            state        <= S_DIFF;
          end else begin
            if (rem_sh >= {1'b0, largest}) begin
              rem <= rem_sh - {1'b0, largest};
              quo <= {quo[31:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[31:0], 1'b0};
            end
            if (div_cnt == 6'd0) begin
              scale_factor <= quo[32:31] != 2'd0 ? 32'hFFFF_FFFF
                : ((rem_sh >= {1'b0, largest}) ? {quo[30:0], 1'b1} : {quo[30:0], 1'b0});
              scale_ready  <= 1'b1;
              state        <= S_DIFF;
            end
            div_cnt <= div_cnt - 6'd1;
          end
        end
        S_DIFF: begin
          neg <= d2 < 0;
          mag <= (d2 < 0) ? 34'(-d2) : 34'(d2);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 66'(mag) * 66'(scale_factor);
          state <= S_SAT;
        end
        S_SAT: begin
          res[axis] <= (scale_factor == 32'd0) ? 18'd0
                     : (neg ? 18'(-{1'b0, r}) : {1'b0, r});
          if (axis == 2'd2) state <= S_OUT;
          else begin
            axis  <= axis + 2'd1;
            state <= S_DIFF;
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> state == S_IDLE)
    else $error("pop outside idle");
  assert property (@(posedge clk) disable iff (rst)
      (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
      state == S_DIFF |-> scale_ready)
    else $error("transform without scale");
endmodule
`default_nettype wire
